FILE: design/bpa_pkg.sv
// Shared types, constants and helpers for the buddy page allocator.
// No dependencies; imported by every module of the block.
package bpa_pkg;

  localparam int MAX_PAGES = 1024;
  localparam int MAX_ORDER = 10;
  localparam int PAGE_W    = $clog2(MAX_PAGES);
  localparam int CNT_W     = PAGE_W + 1;
  localparam int ORD_W     = 4;

  localparam logic [1:0] OP_INIT    = 2'd0;
  localparam logic [1:0] OP_ALLOC   = 2'd1;
  localparam logic [1:0] OP_FREE    = 2'd2;
  localparam logic [1:0] OP_RESERVE = 2'd3;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [ORD_W-1:0]  block_order;
    logic [PAGE_W-1:0] page_index;
    logic [PAGE_W-1:0] end_page;
  } req_t;

  typedef struct packed {
    logic [PAGE_W-1:0] result_page;
    logic              status;
  } rsp_t;

  // One page-table entry: free-head bit and block order
  typedef struct packed {
    logic             free;
    logic [ORD_W-1:0] ord;
  } ent_t;

  typedef enum logic [4:0] {
    CMD_NOP,
    CMD_LOAD,
    CMD_CLEAR_STEP,
    CMD_INIT_START,
    CMD_INIT_STEP,
    CMD_RD_PTR,
    CMD_RD_PAGE,
    CMD_RD_BUDDY,
    CMD_A_START,
    CMD_A_EVAL,
    CMD_A_FAIL,
    CMD_A_PICK,
    CMD_A_WR_HEAD,
    CMD_A_SPLIT,
    CMD_F_MERGE,
    CMD_F_WR,
    CMD_R_START,
    CMD_R_EVAL,
    CMD_R_WR2,
    CMD_PUSH
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       ord_bad;
    logic       pg_oob;
    logic       range_empty;
    logic       ptr_last;
    logic       ptr_zero;
    logic       a_any;
    logic       split_done;
    logic       rd_free;
    logic       rd_match;
    logic       ord_top;
    logic       ord_zero;
    logic       r_split;
    logic       out_free;
  } stat_t;

  // Floor of log2; zero for zero
  function automatic logic [ORD_W-1:0] flog2(input logic [CNT_W-1:0] v);
    logic [ORD_W-1:0] r;
    r = '0;
    for (int i = 0; i < CNT_W; i++) begin
      if (v[i]) r = ORD_W'(i);
    end
    return r;
  endfunction

endpackage

FILE: design/bpa_dpath.sv
// Datapath: page table memory, scan pointer, working registers, output register.
// Depends on bpa_pkg; driven by commands from bpa_ctrl.
module bpa_dpath import bpa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  cmd_t              cmd,
  output stat_t             st,
  input  req_t              in_data,
  input  logic              cfg_valid,
  input  logic [CNT_W-1:0]  cfg_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rsp_t              out_data
);

  // Page table
  ent_t mem [MAX_PAGES];
  ent_t rdata;
  logic we, re;
  logic [PAGE_W-1:0] waddr, raddr;
  ent_t wdata;

  // Working registers
  logic [CNT_W-1:0]  page_count;
  req_t              req;
  logic [PAGE_W-1:0] ptr;
  logic [PAGE_W-1:0] cur_pg;
  logic [ORD_W-1:0]  cur_ord;
  logic [MAX_ORDER:0] found;
  logic [PAGE_W-1:0] found_pg [MAX_ORDER+1];
  logic [PAGE_W-1:0] res_pg;
  logic              res_fail;

  // Derived values
  logic [CNT_W-1:0]  n_pages, rem, blk_last;
  logic              init_head;
  logic [ORD_W-1:0]  lg, init_c, ord_m1, sel;
  logic [PAGE_W-1:0] buddy;
  logic              a_any, r_full, r_split, r_disj, rd_match;

  always_comb begin
    n_pages  = (page_count > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : page_count;
    rem      = n_pages - {1'b0, ptr};
    lg       = flog2(rem);
    init_c   = (lg < cur_ord) ? lg : cur_ord;
    init_head = ({1'b0, ptr} < n_pages) &&
                (({1'b0, ptr} & ((CNT_W'(1) << cur_ord) - CNT_W'(1))) == '0);
    ord_m1   = cur_ord - ORD_W'(1);
    buddy    = cur_pg ^ (PAGE_W'(1) << cur_ord);
    rd_match = rdata.free && (rdata.ord == cur_ord);
    blk_last = {1'b0, ptr} + (CNT_W'(1) << cur_ord) - CNT_W'(1);
    r_full   = ({1'b0, ptr} >= {1'b0, req.page_index}) &&
               (blk_last <= {1'b0, req.end_page});
    r_disj   = ({1'b0, req.page_index} > blk_last) || (req.end_page < ptr);
    r_split  = rd_match && !r_full && !r_disj && (cur_ord != '0);
  end

  // Smallest sufficient order with a recorded free head
  always_comb begin
    sel   = '0;
    a_any = 1'b0;
    for (int i = MAX_ORDER; i >= 0; i--) begin
      if (found[i] && (ORD_W'(i) >= req.block_order)) begin
        sel   = ORD_W'(i);
        a_any = 1'b1;
      end
    end
  end

  // Status to controller
  always_comb begin
    st.op          = req.opcode;
    st.ord_bad     = req.block_order > ORD_W'(MAX_ORDER);
    st.pg_oob      = {1'b0, req.page_index} >= n_pages;
    st.range_empty = req.end_page < req.page_index;
    st.ptr_last    = ptr == PAGE_W'(MAX_PAGES - 1);
    st.ptr_zero    = ptr == '0;
    st.a_any       = a_any;
    st.split_done  = cur_ord == req.block_order;
    st.rd_free     = rdata.free;
    st.rd_match    = rd_match;
    st.ord_top     = cur_ord >= ORD_W'(MAX_ORDER);
    st.ord_zero    = cur_ord == '0;
    st.r_split     = r_split;
    st.out_free    = !out_valid || out_ready;
  end

  // Memory port selection
  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = ptr;
    raddr = ptr;
    wdata = '0;
    case (cmd)
      CMD_CLEAR_STEP: we = 1'b1;
      CMD_INIT_STEP: begin
        we    = 1'b1;
        wdata = init_head ? ent_t'{free: 1'b1, ord: init_c} : '0;
      end
      CMD_RD_PTR:   re = 1'b1;
      CMD_RD_PAGE: begin
        re    = 1'b1;
        raddr = req.page_index;
      end
      CMD_RD_BUDDY: begin
        re    = 1'b1;
        raddr = buddy;
      end
      CMD_A_WR_HEAD: begin
        we    = 1'b1;
        waddr = cur_pg;
      end
      CMD_A_SPLIT: begin
        we    = 1'b1;
        waddr = cur_pg ^ (PAGE_W'(1) << ord_m1);
        wdata = ent_t'{free: 1'b1, ord: ord_m1};
      end
      CMD_F_MERGE: begin
        we    = 1'b1;
        waddr = buddy;
      end
      CMD_F_WR: begin
        we    = 1'b1;
        waddr = cur_pg;
        wdata = ent_t'{free: 1'b1, ord: cur_ord};
      end
      CMD_R_EVAL: begin
        we    = (rd_match && r_full) || r_split;
        wdata = r_split ? ent_t'{free: 1'b1, ord: ord_m1} : '0;
      end
      CMD_R_WR2: begin
        we    = 1'b1;
        waddr = ptr ^ (PAGE_W'(1) << ord_m1);
        wdata = ent_t'{free: 1'b1, ord: ord_m1};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      page_count <= CNT_W'(MAX_PAGES);
      out_valid  <= 1'b0;
    end else begin
      if (cfg_valid) page_count <= cfg_data;
      if (cmd == CMD_PUSH) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr   <= '0;
      found <= '0;
    end else begin
      case (cmd)
        CMD_LOAD: begin
          req      <= in_data;
          res_pg   <= '0;
          res_fail <= 1'b0;
        end
        CMD_CLEAR_STEP: ptr <= ptr + PAGE_W'(1);
        CMD_INIT_START, CMD_R_START: begin
          ptr     <= '0;
          cur_ord <= ORD_W'(MAX_ORDER);
        end
        CMD_INIT_STEP: begin
          ptr <= ptr + PAGE_W'(1);
          if (init_head) cur_ord <= init_c;
        end
        CMD_A_START: begin
          ptr   <= PAGE_W'(MAX_PAGES - 1);
          found <= '0;
        end
        CMD_A_EVAL: begin
          if (rdata.free && rdata.ord <= ORD_W'(MAX_ORDER) && !found[rdata.ord]) begin
            found[rdata.ord]    <= 1'b1;
            found_pg[rdata.ord] <= ptr;
          end
          ptr <= ptr - PAGE_W'(1);
        end
        CMD_A_FAIL: res_fail <= 1'b1;
        CMD_A_PICK: begin
          cur_pg  <= found_pg[sel];
          cur_ord <= sel;
          res_pg  <= found_pg[sel];
        end
        CMD_A_SPLIT: cur_ord <= ord_m1;
        CMD_RD_PAGE: begin
          cur_pg  <= req.page_index;
          cur_ord <= req.block_order;
        end
        CMD_F_MERGE: begin
          if (buddy < cur_pg) cur_pg <= buddy;
          cur_ord <= cur_ord + ORD_W'(1);
        end
        CMD_R_EVAL, CMD_R_WR2: begin
          // advance the sweep unless a second split write is pending
          if (cmd == CMD_R_WR2 || !r_split) begin
            ptr <= ptr + PAGE_W'(1);
            if (ptr == PAGE_W'(MAX_PAGES - 1)) cur_ord <= ord_m1;
          end
        end
        CMD_PUSH: out_data <= rsp_t'{result_page: res_pg, status: res_fail};
        default: ;
      endcase
    end
  end

endmodule

FILE: design/bpa_ctrl.sv
// Controller state machine: sequences each operation over the datapath.
// Depends on bpa_pkg; talks to bpa_dpath through cmd_t and stat_t.
module bpa_ctrl import bpa_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t st,
  output cmd_t  cmd
);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_INIT,
    ST_A_RD, ST_A_EV, ST_A_PICK, ST_A_WH, ST_A_SPL,
    ST_F_CHK, ST_F_LOOP, ST_F_BCHK,
    ST_R_RD, ST_R_EV, ST_R_WR2, ST_DONE
  } state_t;

  state_t state, state_next;

  assign in_ready = state == ST_IDLE;

  // Next state and command
  always_comb begin
    state_next = state;
    cmd        = CMD_NOP;
    case (state)
      ST_CLEAR: begin
        cmd = CMD_CLEAR_STEP;
        if (st.ptr_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd        = CMD_LOAD;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        case (st.op)
          OP_INIT: begin
            cmd        = CMD_INIT_START;
            state_next = ST_INIT;
          end
          OP_ALLOC: begin
            if (st.ord_bad) begin
              cmd        = CMD_A_FAIL;
              state_next = ST_DONE;
            end else begin
              cmd        = CMD_A_START;
              state_next = ST_A_RD;
            end
          end
          OP_FREE: begin
            if (st.ord_bad || st.pg_oob) begin
              state_next = ST_DONE;
            end else begin
              cmd        = CMD_RD_PAGE;
              state_next = ST_F_CHK;
            end
          end
          default: begin
            if (st.range_empty) begin
              state_next = ST_DONE;
            end else begin
              cmd        = CMD_R_START;
              state_next = ST_R_RD;
            end
          end
        endcase
      end
      ST_INIT: begin
        cmd = CMD_INIT_STEP;
        if (st.ptr_last) state_next = ST_DONE;
      end
      // Allocate: descending scan, then pick and split
      ST_A_RD: begin
        cmd        = CMD_RD_PTR;
        state_next = ST_A_EV;
      end
      ST_A_EV: begin
        cmd        = CMD_A_EVAL;
        state_next = st.ptr_zero ? ST_A_PICK : ST_A_RD;
      end
      ST_A_PICK: begin
        if (st.a_any) begin
          cmd        = CMD_A_PICK;
          state_next = ST_A_WH;
        end else begin
          cmd        = CMD_A_FAIL;
          state_next = ST_DONE;
        end
      end
      ST_A_WH: begin
        cmd        = CMD_A_WR_HEAD;
        state_next = ST_A_SPL;
      end
      ST_A_SPL: begin
        if (st.split_done) begin
          state_next = ST_DONE;
        end else begin
          cmd = CMD_A_SPLIT;
        end
      end
      // Free: check head, then merge with buddies
      ST_F_CHK: begin
        state_next = st.rd_free ? ST_DONE : ST_F_LOOP;
      end
      ST_F_LOOP: begin
        if (st.ord_top) begin
          cmd        = CMD_F_WR;
          state_next = ST_DONE;
        end else begin
          cmd        = CMD_RD_BUDDY;
          state_next = ST_F_BCHK;
        end
      end
      ST_F_BCHK: begin
        if (st.rd_match) begin
          cmd        = CMD_F_MERGE;
          state_next = ST_F_LOOP;
        end else begin
          cmd        = CMD_F_WR;
          state_next = ST_DONE;
        end
      end
      // Reserve: sweep all pages once per order, largest first
      ST_R_RD: begin
        cmd        = CMD_RD_PTR;
        state_next = ST_R_EV;
      end
      ST_R_EV: begin
        cmd = CMD_R_EVAL;
        if (st.r_split) state_next = ST_R_WR2;
        else if (st.ptr_last && st.ord_zero) state_next = ST_DONE;
        else state_next = ST_R_RD;
      end
      ST_R_WR2: begin
        cmd        = CMD_R_WR2;
        state_next = (st.ptr_last && st.ord_zero) ? ST_DONE : ST_R_RD;
      end
      ST_DONE: begin
        if (st.out_free) begin
          cmd        = CMD_PUSH;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: design/buddy_page_allocator_core.sv
// Top level of the buddy page allocator: controller plus datapath.
// Depends on bpa_pkg, bpa_ctrl, bpa_dpath.
//
//  channel | signals                     | direction | payload
//  in      | in_valid, in_ready, in_data | to block  | req_t (opcode, order, pages)
//  out     | out_valid, out_ready, out_data | from block | rsp_t (result_page, status)
//  cfg     | cfg_valid, cfg_ready, cfg_data | to block  | page_count, 11 bits
//
// Reset runs a clearing pass over the page table; no item is taken then.
// Init: one page table write per page.
// Allocate: a descending single-port scan of every page, then the split levels.
// Free: one buddy read and check per merge level.
// Reserve: one sweep of the table per order, plus an extra write per split block.
// A result waiting on out_ready holds only the final push; the next item is taken meanwhile.
module buddy_page_allocator_core import bpa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  req_t              in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rsp_t              out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CNT_W-1:0]  cfg_data
);

  cmd_t  cmd;
  stat_t st;

  assign cfg_ready = 1'b1;

  bpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  bpa_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

FILE: design/bpa_checker.sv
// Port-level checks for the buddy page allocator, bound to the top level.
// Depends on bpa_pkg and buddy_page_allocator_core.
module bpa_checker import bpa_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input rsp_t             out_data,
  input logic             cfg_ready
);

  // A waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Reset empties the output register
  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A failed allocation reports page zero
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status |-> out_data.result_page == '0)
    else $error("failure with nonzero page");

  // One transaction at a time: no accept in the cycle after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("back-to-back accept");

  // Config writes are always taken
  a_cfg_rdy: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("config port not ready");

endmodule

bind buddy_page_allocator_core bpa_checker u_bpa_checker (.*);

FILE: tb/buddy_page_allocator_core_tb.sv
// Self-checking testbench for buddy_page_allocator_core: directed and random requests,
// predicted by a page-table model held here. Depends on bpa_pkg and the core RTL.
`timescale 1ns / 1ps

module buddy_page_allocator_core_tb;
  import bpa_pkg::*;

  typedef struct {
    bit               is_cfg;
    req_t             req;
    logic [CNT_W-1:0] count;
  } pend_t;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  req_t             in_data;
  logic             out_valid;
  logic             out_ready;
  rsp_t             out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data;

  pend_t pending_q[$];
  rsp_t  expected_rsp_q[$];
  int    errors;
  int    send_gap;
  int    idle_wait;
  int    rsp_stall;
  bit    calm;

  // page table copy kept by the predictor
  bit          tbl_free[MAX_PAGES];
  bit [3:0]    tbl_ord[MAX_PAGES];
  bit          tbl_used[MAX_PAGES];
  int unsigned managed_pages;

  buddy_page_allocator_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void mark_free(int unsigned p, int unsigned ord);
    if (p >= MAX_PAGES) return;
    tbl_free[p] = 1'b1;
    tbl_ord[p]  = ord[3:0];
    tbl_used[p] = 1'b0;
  endfunction

  function automatic bit free_head(int unsigned p, int unsigned ord);
    return p < MAX_PAGES && tbl_free[p] && tbl_ord[p] == ord;
  endfunction

  function automatic int unsigned active_pages();
    return managed_pages < MAX_PAGES ? managed_pages : MAX_PAGES;
  endfunction

  function automatic void clear_table();
    for (int i = 0; i < MAX_PAGES; i++) begin
      tbl_free[i] = 1'b0;
      tbl_ord[i]  = '0;
      tbl_used[i] = 1'b0;
    end
  endfunction

  // carve managed pages greedily from page 0
  function automatic void carve_pages();
    int unsigned n;
    int unsigned cur;
    n = active_pages();
    cur = MAX_ORDER;
    clear_table();
    for (int unsigned i = 0; i < n; i++) begin
      if ((i & ((1 << cur) - 1)) == 0) begin
        while (cur > 0 && n - i < (1 << cur)) cur--;
        mark_free(i, cur);
      end
    end
  endfunction

  // highest free head of the smallest fitting order, split keeping the low half
  function automatic rsp_t take_block(int unsigned ord);
    rsp_t r;
    int   p;
    r = '{result_page: '0, status: 1'b1};
    if (ord > MAX_ORDER) return r;
    for (int unsigned i = ord; i <= MAX_ORDER; i++) begin
      p = -1;
      for (int q = MAX_PAGES - 1; q >= 0; q--) begin
        if (free_head(q, i)) begin
          p = q;
          break;
        end
      end
      if (p < 0) continue;
      tbl_free[p] = 1'b0;
      tbl_used[p] = 1'b1;
      tbl_ord[p]  = ord[3:0];
      while (i > ord) begin
        i--;
        mark_free(p ^ (1 << i), i);
      end
      r.result_page = p[PAGE_W-1:0];
      r.status = 1'b0;
      return r;
    end
    return r;
  endfunction

  // release with buddy merging
  function automatic void release_block(int unsigned p, int unsigned ord);
    int unsigned cur;
    int unsigned b;
    cur = p;
    if (ord > MAX_ORDER || p >= active_pages() || tbl_free[p]) return;
    while (ord < MAX_ORDER) begin
      b = cur ^ (1 << ord);
      if (!free_head(b, ord)) break;
      tbl_free[b] = 1'b0;
      if (b < cur) begin
        tbl_free[cur] = 1'b0;
        cur = b;
      end
      ord++;
    end
    mark_free(cur, ord);
  endfunction

  // pull a page range out, splitting partly covered blocks
  function automatic void reserve_range(int unsigned lo, int unsigned hi);
    int unsigned last;
    if (hi < lo) return;
    for (int o = MAX_ORDER; o >= 0; o--) begin
      for (int unsigned p = 0; p < MAX_PAGES; p++) begin
        if (!free_head(p, o)) continue;
        last = p + (1 << o) - 1;
        if (p >= lo && last <= hi) begin
          tbl_free[p] = 1'b0;
          tbl_used[p] = 1'b1;
        end else if (lo > last || hi < p) begin
        end else if (o > 0) begin
          mark_free(p, o - 1);
          mark_free(p ^ (1 << (o - 1)), o - 1);
        end
      end
    end
  endfunction

  function automatic rsp_t predict_rsp(req_t rq);
    rsp_t r;
    r = '{result_page: '0, status: 1'b0};
    case (rq.opcode)
      OP_INIT:    carve_pages();
      OP_ALLOC:   r = take_block(rq.block_order);
      OP_FREE:    release_block(rq.page_index, rq.block_order);
      OP_RESERVE: reserve_range(rq.page_index, rq.end_page);
      default: ;
    endcase
    return r;
  endfunction

  function automatic void push_req(logic [1:0] op, int unsigned ord, int unsigned pg,
                                   int unsigned last);
    pend_t t;
    t.is_cfg = 1'b0;
    t.count = '0;
    t.req = '{opcode: op, block_order: ord[ORD_W-1:0], page_index: pg[PAGE_W-1:0],
              end_page: last[PAGE_W-1:0]};
    pending_q.push_back(t);
  endfunction

  function automatic void push_cfg(int unsigned cnt);
    pend_t t;
    t.is_cfg = 1'b1;
    t.req = '0;
    t.count = cnt[CNT_W-1:0];
    pending_q.push_back(t);
  endfunction

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, 6);
  endfunction

  // driver: requests and config writes, config only with nothing outstanding
  always @(posedge clk) begin
    bit    v;
    bit    cv;
    pend_t t;
    if (rst) begin
      in_valid  <= 1'b0;
      cfg_valid <= 1'b0;
      send_gap  = 0;
      idle_wait = 0;
    end else begin
      v = in_valid;
      cv = cfg_valid;
      if (in_valid && in_ready) begin
        expected_rsp_q.push_back(predict_rsp(in_data));
        v = 1'b0;
        if ($urandom_range(0, 60) == 0) calm = ~calm;
        send_gap = draw_gap();
      end
      if (cfg_valid && cfg_ready) begin
        managed_pages = cfg_data;
        cv = 1'b0;
        send_gap = draw_gap();
      end
      if (!v && !cv) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_q.size() > 0) begin
          if (pending_q[0].is_cfg) begin
            if (expected_rsp_q.size() == 0 && !out_valid) begin
              idle_wait++;
              if (idle_wait >= 8) begin
                t = pending_q.pop_front();
                cfg_data <= t.count;
                cv = 1'b1;
                idle_wait = 0;
              end
            end else begin
              idle_wait = 0;
            end
          end else begin
            t = pending_q.pop_front();
            in_data <= t.req;
            v = 1'b1;
          end
        end
      end
      in_valid  <= v;
      cfg_valid <= cv;
    end
  end

  // monitor: random back-pressure, compare against oldest expectation
  always @(posedge clk) begin
    rsp_t e;
    if (rst) begin
      out_ready <= 1'b0;
      rsp_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_rsp_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected transaction page=%0d status=%0b", $time,
                   out_data.result_page, out_data.status);
        end else begin
          e = expected_rsp_q.pop_front();
          if (out_data.result_page !== e.result_page) begin
            errors++;
            $display("%0t: result_page expected %0d actual %0d", $time,
                     e.result_page, out_data.result_page);
          end
          if (out_data.status !== e.status) begin
            errors++;
            $display("%0t: status expected %0b actual %0b", $time, e.status,
                     out_data.status);
          end
        end
        rsp_stall = draw_gap();
      end
      if (rsp_stall > 0) begin
        rsp_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // stimulus
  initial begin
    int unsigned cnt;
    int unsigned ord;
    int unsigned pg;
    int unsigned span;
    int unsigned r;
    errors = 0;
    calm = 1'b0;
    managed_pages = 1024;
    clear_table();
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    out_ready = 1'b0;

    // directed
    push_req(OP_ALLOC, 0, 0, 0);
    push_cfg(1024);
    push_req(OP_INIT, 0, 0, 0);
    push_req(OP_ALLOC, 10, 0, 0);
    push_req(OP_ALLOC, 11, 0, 0);
    push_req(OP_FREE, 15, 0, 0);
    push_req(OP_FREE, 10, 0, 0);
    push_req(OP_FREE, 10, 0, 0);
    push_req(OP_ALLOC, 0, 0, 0);
    push_req(OP_FREE, 0, 1023, 0);
    push_req(OP_ALLOC, 15, 1023, 1023);
    push_req(OP_RESERVE, 0, 700, 5);
    push_req(OP_RESERVE, 0, 5, 700);
    push_req(OP_FREE, 3, 8, 0);
    push_req(OP_RESERVE, 0, 1023, 1023);
    push_cfg(0);
    push_req(OP_INIT, 0, 0, 0);
    push_req(OP_ALLOC, 0, 0, 0);
    push_cfg(1);
    push_req(OP_INIT, 0, 0, 0);
    push_req(OP_ALLOC, 0, 0, 0);
    push_req(OP_FREE, 0, 5, 0);
    push_req(OP_FREE, 0, 0, 0);
    push_cfg(2047);
    push_req(OP_INIT, 0, 0, 0);
    push_req(OP_ALLOC, 1, 0, 0);

    // random phases: a page count, an init, then a mix of traffic
    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 5)
        0: cnt = 1024;
        1: cnt = $urandom_range(1, 64);
        2: cnt = $urandom_range(1, 2047);
        3: cnt = (ph == 3) ? 2047 : $urandom_range(1, 16);
        default: cnt = (ph == 4) ? 1 : $urandom_range(100, 1024);
      endcase
      push_cfg(cnt);
      push_req(OP_INIT, 0, 0, 0);
      for (int k = 0; k < 100; k++) begin
        r = $urandom_range(0, 199);
        ord = ($urandom_range(0, 19) == 0) ? $urandom_range(11, 15) : $urandom_range(0, 4);
        if ($urandom_range(0, 9) == 0) ord = $urandom_range(5, 10);
        if (r < 100) begin
          push_req(OP_ALLOC, ord, $urandom, $urandom);
        end else if (r < 194) begin
          pg = $urandom_range(0, (cnt < MAX_PAGES ? cnt : MAX_PAGES) - 1);
          if (r < 180 && ord <= MAX_ORDER) pg = pg & ~((1 << ord) - 1);
          if (r >= 190) pg = $urandom_range(0, 1023);
          push_req(OP_FREE, ord, pg, $urandom);
        end else if (r < 196) begin
          pg = $urandom_range(0, 1023);
          span = $urandom_range(0, 40);
          push_req(OP_RESERVE, $urandom, pg, (r == 195) ? $urandom : pg + span);
        end else if (r < 197) begin
          push_req(OP_INIT, $urandom, $urandom, $urandom);
        end else begin
          push_req(OP_ALLOC, ord, $urandom, $urandom);
        end
      end
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    forever begin
      @(posedge clk);
      if (pending_q.size() == 0 && !in_valid && !cfg_valid && expected_rsp_q.size() == 0)
        break;
    end
    repeat (64) @(posedge clk);
    if (errors == 0) $display("buddy_page_allocator_core_tb: clean");
    else $display("buddy_page_allocator_core_tb: errors");
    $finish;
  end

  initial begin
    #(64'd300_000_000);
    $display("buddy_page_allocator_core_tb: errors");
    $finish;
  end

endmodule
